[rtl/bmp_stream_decoder_assert.svh]
// Assertion macros shared by the decoder RTL.
// Both sample on i_clk and stay quiet while i_rst_n is low.
`ifndef BMP_STREAM_DECODER_ASSERT_SVH
`define BMP_STREAM_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bmp_stream_decoder: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bmp_stream_decoder: next-cycle check failed");

`endif

[rtl/bsd_pkg.sv]
`timescale 1ns / 1ps

package bsd_pkg;

    localparam int ADDR_W = 26;
    localparam int DIM_W  = 13;

    // result kinds
    localparam logic [1:0] KIND_INFO  = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [3:0] ERR_SIGNATURE = 4'd0;
    localparam logic [3:0] ERR_DIB_SMALL = 4'd1;
    localparam logic [3:0] ERR_PLANES    = 4'd2;
    localparam logic [3:0] ERR_DIMS      = 4'd3;
    localparam logic [3:0] ERR_COMPRESS  = 4'd4;
    localparam logic [3:0] ERR_DEPTH     = 4'd5;
    localparam logic [3:0] ERR_OFFSET    = 4'd6;
    localparam logic [3:0] ERR_TOO_BIG   = 4'd7;
    localparam logic [3:0] ERR_TRUNCATED = 4'd8;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4d42;
    localparam logic [31:0] DIB_MIN_SIZE  = 32'd40;
    localparam logic [31:0] HDR_SIZE      = 32'd54;
    localparam logic [15:0] BPP_24        = 16'd24;
    localparam logic [15:0] BPP_8         = 16'd8;
    localparam logic [1:0]  CHAN_BGR      = 2'd3;
    localparam logic [1:0]  CHAN_GRAY     = 2'd1;

    // header byte positions where checks fire
    localparam logic [5:0] POS_SIG_DONE    = 6'd1;
    localparam logic [5:0] POS_DIB_DONE    = 6'd17;
    localparam logic [5:0] POS_PLANES_DONE = 6'd27;
    localparam logic [5:0] POS_HDR_LAST    = 6'd53;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [7:0]        pixel_byte;
        logic [ADDR_W-1:0] dest_address;
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
        logic [1:0]        channel_count;
        logic [3:0]        error_code;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] signature;
        logic [31:0] data_offset;
        logic [31:0] info_size;
        logic [31:0] width;
        logic [31:0] height;
        logic [15:0] planes;
        logic [15:0] bpp;
        logic [31:0] compression;
    } t_hdr_fields;

    typedef struct packed {
        logic       fail;
        logic [3:0] code;
        logic       done;
    } t_hdr_verdict;

endpackage

[rtl/bsd_hdr_chk.sv]
`timescale 1ns / 1ps

module bsd_hdr_chk #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  bsd_pkg::t_hdr_fields  i_fields,
    input  logic [5:0]            i_hdr_pos,
    output bsd_pkg::t_hdr_verdict o_verdict
);

    logic [31:0] height_mag;

    always_comb begin
        height_mag = i_fields.height[31] ? (32'd0 - i_fields.height) : i_fields.height;
        o_verdict = '0;
        if (i_hdr_pos == bsd_pkg::POS_SIG_DONE) begin
            if (i_fields.signature != bsd_pkg::BMP_SIGNATURE) begin
                o_verdict.fail = 1'b1;
                o_verdict.code = bsd_pkg::ERR_SIGNATURE;
            end
        end else if (i_hdr_pos == bsd_pkg::POS_DIB_DONE) begin
            if (i_fields.info_size < bsd_pkg::DIB_MIN_SIZE) begin
                o_verdict.fail = 1'b1;
                o_verdict.code = bsd_pkg::ERR_DIB_SMALL;
            end
        end else if (i_hdr_pos == bsd_pkg::POS_PLANES_DONE) begin
            if (i_fields.planes != 16'd1) begin
                o_verdict.fail = 1'b1;
                o_verdict.code = bsd_pkg::ERR_PLANES;
            end
        end else if (i_hdr_pos == bsd_pkg::POS_HDR_LAST) begin
            // priority follows the order the fields are judged
            o_verdict.fail = 1'b1;
            if (i_fields.width[31] || i_fields.width == 32'd0 || i_fields.height == 32'd0) begin
                o_verdict.code = bsd_pkg::ERR_DIMS;
            end else if (i_fields.compression != 32'd0) begin
                o_verdict.code = bsd_pkg::ERR_COMPRESS;
            end else if (i_fields.bpp != bsd_pkg::BPP_24 && i_fields.bpp != bsd_pkg::BPP_8) begin
                o_verdict.code = bsd_pkg::ERR_DEPTH;
            end else if (i_fields.width > 32'(MAX_WIDTH) || height_mag > 32'(MAX_HEIGHT)) begin
                o_verdict.code = bsd_pkg::ERR_TOO_BIG;
            end else if (i_fields.data_offset < bsd_pkg::HDR_SIZE) begin
                o_verdict.code = bsd_pkg::ERR_OFFSET;
            end else begin
                o_verdict.fail = 1'b0;
                o_verdict.done = 1'b1;
            end
        end
    end

endmodule

[rtl/bmp_stream_decoder.sv]
`timescale 1ns / 1ps

// Uncompressed BMP decoder, one file byte per input item.
// Input channel: i_in_valid / o_in_ready, payload i_in_data (stream_byte,
// end_of_stream). Output channel: o_out_valid / i_out_ready, payload
// o_out_data. Each accepted item yields at most one result: frame info
// after the 54-byte header, one pixel item per pixel byte (padding and the
// gap before the pixel offset give nothing), or an error.
// Latency: a result is visible the cycle after its item is accepted.
// Throughput: one item per cycle unless stalled; each byte crosses one layer
// of parse logic between the input handshake and the single result register.
// The row base for bottom-up files comes from a registered multiplier that
// settles during the header bytes, so it never holds back the info result.
// When the receiver stalls, the result register holds and o_in_ready drops
// until it is taken; with the register empty or draining, items flow on.
// After an error, bytes are dropped until an end marker. An end marker
// rearms the parser; it reports truncation if the frame was not complete.
// Reset (synchronous, active low) empties the result register and returns
// the parser to the header state; no clearing pass is needed.
module bmp_stream_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bsd_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bsd_pkg::t_out_item o_out_data
);

    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = $clog2(3 * MAX_WIDTH + 4);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = HW + CW;
    localparam int AW = bsd_pkg::ADDR_W;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PIXELS = 3'd2;
    localparam logic [2:0] PH_DONE   = 3'd3;
    localparam logic [2:0] PH_ERROR  = 3'd4;

    logic [2:0]            r_phase, n_phase;
    logic [31:0]           r_pos, n_pos;
    bsd_pkg::t_hdr_fields  r_fields, n_fields, m_fields;
    logic [HW-1:0]         r_abs_h;
    logic [CW-1:0]         r_row_bytes;
    logic [CW-1:0]         r_stride;
    logic [AW-1:0]         r_flip_base;
    logic [HW-1:0]         r_row, n_row;
    logic [CW-1:0]         r_col, n_col;
    logic [AW-1:0]         r_row_start, n_row_start;
    logic                  r_out_valid, n_out_valid;
    bsd_pkg::t_out_item    r_out, n_out;

    bsd_pkg::t_hdr_verdict verdict;
    logic                  load;
    logic                  emit;
    logic [5:0]            hdr_pos;
    logic [5:0]            lane_off;
    logic [31:0]           abs32;
    logic                  is_bgr;
    logic [WW-1:0]         width_lo;
    logic [CW-1:0]         rb_calc;
    logic [PW-1:0]         flip_prod;
    logic                  pix_go;
    logic [CW:0]           col_nx;
    logic [HW:0]           row_nx;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign load        = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign hdr_pos     = r_pos[5:0];

    // derived frame geometry, settled long before the last header byte
    always_comb begin
        abs32     = r_fields.height[31] ? (32'd0 - r_fields.height) : r_fields.height;
        is_bgr    = r_fields.bpp == bsd_pkg::BPP_24;
        width_lo  = r_fields.width[WW-1:0];
        rb_calc   = is_bgr ? (CW'(width_lo) + CW'({width_lo, 1'b0})) : CW'(width_lo);
        flip_prod = PW'(r_abs_h - 1'b1) * PW'(r_row_bytes);
    end

    // place the incoming byte into its little-endian header field
    always_comb begin
        m_fields = r_fields;
        lane_off = 6'd0;
        if (hdr_pos < 6'd2) begin
            m_fields.signature[{hdr_pos[0], 3'b000} +: 8] = i_in_data.stream_byte;
        end else if (hdr_pos >= 6'd10 && hdr_pos < 6'd14) begin
            lane_off = hdr_pos - 6'd10;
            m_fields.data_offset[{lane_off[1:0], 3'b000} +: 8] = i_in_data.stream_byte;
        end else if (hdr_pos >= 6'd14 && hdr_pos < 6'd18) begin
            lane_off = hdr_pos - 6'd14;
            m_fields.info_size[{lane_off[1:0], 3'b000} +: 8] = i_in_data.stream_byte;
        end else if (hdr_pos >= 6'd18 && hdr_pos < 6'd22) begin
            lane_off = hdr_pos - 6'd18;
            m_fields.width[{lane_off[1:0], 3'b000} +: 8] = i_in_data.stream_byte;
        end else if (hdr_pos >= 6'd22 && hdr_pos < 6'd26) begin
            lane_off = hdr_pos - 6'd22;
            m_fields.height[{lane_off[1:0], 3'b000} +: 8] = i_in_data.stream_byte;
        end else if (hdr_pos >= 6'd26 && hdr_pos < 6'd28) begin
            lane_off = hdr_pos - 6'd26;
            m_fields.planes[{lane_off[0], 3'b000} +: 8] = i_in_data.stream_byte;
        end else if (hdr_pos >= 6'd28 && hdr_pos < 6'd30) begin
            lane_off = hdr_pos - 6'd28;
            m_fields.bpp[{lane_off[0], 3'b000} +: 8] = i_in_data.stream_byte;
        end else if (hdr_pos >= 6'd30 && hdr_pos < 6'd34) begin
            lane_off = hdr_pos - 6'd30;
            m_fields.compression[{lane_off[1:0], 3'b000} +: 8] = i_in_data.stream_byte;
        end
    end

    bsd_hdr_chk #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_hdr_chk (
        .i_fields  (m_fields),
        .i_hdr_pos (hdr_pos),
        .o_verdict (verdict)
    );

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_fields    = r_fields;
        n_row       = r_row;
        n_col       = r_col;
        n_row_start = r_row_start;
        emit        = 1'b0;
        n_out       = '0;
        pix_go      = (r_phase == PH_PIXELS) ||
                      (r_phase == PH_SKIP && r_pos >= r_fields.data_offset);
        col_nx      = {1'b0, r_col} + 1'b1;
        row_nx      = {1'b0, r_row} + 1'b1;

        if (i_in_data.end_of_stream) begin
            n_phase     = PH_HEADER;
            n_pos       = '0;
            n_row       = '0;
            n_col       = '0;
            n_row_start = '0;
            if (r_phase != PH_DONE && r_phase != PH_ERROR) begin
                emit              = 1'b1;
                n_out.result_kind = bsd_pkg::KIND_ERROR;
                n_out.error_code  = bsd_pkg::ERR_TRUNCATED;
            end
        end else begin
            if (r_pos != '1) begin
                n_pos = r_pos + 32'd1;
            end
            if (r_phase == PH_HEADER) begin
                n_fields = m_fields;
                if (verdict.fail) begin
                    n_phase           = PH_ERROR;
                    emit              = 1'b1;
                    n_out.result_kind = bsd_pkg::KIND_ERROR;
                    n_out.error_code  = verdict.code;
                end else if (verdict.done) begin
                    n_phase             = PH_SKIP;
                    n_row               = '0;
                    n_col               = '0;
                    n_row_start         = r_fields.height[31] ? '0 : r_flip_base;
                    emit                = 1'b1;
                    n_out.result_kind   = bsd_pkg::KIND_INFO;
                    n_out.frame_width   = r_fields.width[bsd_pkg::DIM_W-1:0];
                    n_out.frame_height  = abs32[bsd_pkg::DIM_W-1:0];
                    n_out.channel_count = is_bgr ? bsd_pkg::CHAN_BGR : bsd_pkg::CHAN_GRAY;
                end
            end else if (pix_go) begin
                n_phase = PH_PIXELS;
                if (r_col < r_row_bytes) begin
                    emit               = 1'b1;
                    n_out.result_kind  = bsd_pkg::KIND_PIXEL;
                    n_out.pixel_byte   = i_in_data.stream_byte;
                    n_out.dest_address = r_row_start + AW'(r_col);
                    n_out.last         = (row_nx == {1'b0, r_abs_h}) &&
                                         (col_nx == {1'b0, r_row_bytes});
                end
                // drop padding, then advance to the next row
                if (col_nx >= {1'b0, r_stride}) begin
                    n_col = '0;
                    n_row = row_nx[HW-1:0];
                    if (r_fields.height[31]) begin
                        n_row_start = r_row_start + AW'(r_row_bytes);
                    end else begin
                        n_row_start = r_row_start - AW'(r_row_bytes);
                    end
                    if (row_nx >= {1'b0, r_abs_h}) begin
                        n_phase = PH_DONE;
                    end
                end else begin
                    n_col = col_nx[CW-1:0];
                end
            end
        end

        if (load) begin
            n_out_valid = emit;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (load) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_abs_h     <= abs32[HW-1:0];
        r_row_bytes <= rb_calc;
        r_stride    <= (rb_calc + CW'(3)) & ~CW'(3);
        r_flip_base <= AW'(flip_prod);
        if (load) begin
            r_fields    <= n_fields;
            r_row       <= n_row;
            r_col       <= n_col;
            r_row_start <= n_row_start;
            if (emit) begin
                r_out <= n_out;
            end
        end
    end

`include "bmp_stream_decoder_assert.svh"

    `BSD_ASSERT_NEXT(a_eos_rearms, load && i_in_data.end_of_stream, r_phase == PH_HEADER && r_pos == 32'd0)
    `BSD_ASSERT_NEXT(a_fail_enters_error, load && !i_in_data.end_of_stream && r_phase == PH_HEADER && verdict.fail, r_phase == PH_ERROR && r_out_valid && r_out.result_kind == bsd_pkg::KIND_ERROR)
    `BSD_ASSERT_NOW(a_last_only_pixel, r_out_valid && r_out.last, r_out.result_kind == bsd_pkg::KIND_PIXEL)
    `BSD_ASSERT_NOW(a_col_in_stride, r_phase == PH_PIXELS, r_col < r_stride)

endmodule

[dv/bmp_result_tracker_pkg.sv]
`timescale 1ns / 1ps

package bmp_result_tracker_pkg;
    import bsd_pkg::*;

    localparam int FRAME_MAX_W = 4096;
    localparam int FRAME_MAX_H = 4096;

    typedef enum logic [2:0] {
        PARSE_HEADER,
        PARSE_SKIP,
        PARSE_PIXELS,
        PARSE_DONE,
        PARSE_ERROR
    } parse_phase_e;

    // Tracks the decoder's parse state byte by byte and queues the results
    // it should produce; results coming back are matched in order.
    class bmp_result_tracker;
        parse_phase_e phase;
        logic [31:0]  position;
        logic [31:0]  signature;
        logic [31:0]  data_start;
        logic [31:0]  info_len;
        logic [31:0]  width;
        logic [31:0]  height;
        logic [31:0]  planes;
        logic [31:0]  bpp;
        logic [31:0]  compression;
        logic [31:0]  row_count;
        logic [31:0]  stride_column;
        logic [31:0]  row_base;

        t_out_item    expected_results[$];
        int           mismatches;
        int           frame_infos;
        int           pixel_items;
        int           frame_ends;
        int           error_items;
        logic [15:0]  codes_seen;

        function new();
            rearm();
            mismatches  = 0;
            frame_infos = 0;
            pixel_items = 0;
            frame_ends  = 0;
            error_items = 0;
            codes_seen  = '0;
        endfunction

        function void rearm();
            phase         = PARSE_HEADER;
            position      = '0;
            signature     = '0;
            data_start    = '0;
            info_len      = '0;
            width         = '0;
            height        = '0;
            planes        = '0;
            bpp           = '0;
            compression   = '0;
            row_count     = '0;
            stride_column = '0;
            row_base      = '0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function logic [31:0] channels();
            return (bpp == 32'(BPP_24)) ? 32'd3 : 32'd1;
        endfunction

        function logic [31:0] height_mag();
            return height[31] ? (32'd0 - height) : height;
        endfunction

        function logic [31:0] row_len();
            return width * channels();
        endfunction

        function void push_error(logic [3:0] code, bit halt);
            t_out_item r;
            r = '0;
            r.result_kind = KIND_ERROR;
            r.error_code  = code;
            if (halt) phase = PARSE_ERROR;
            expected_results.push_back(r);
        endfunction

        // place a header byte in its little-endian lane
        function logic [31:0] lane(logic [7:0] b, logic [31:0] p, logic [31:0] start);
            logic [31:0] sh;
            sh = (p - start) & 32'd3;
            return {24'd0, b} << (sh * 8);
        endfunction

        function void header_byte(logic [31:0] p, logic [7:0] b);
            t_out_item   r;
            logic [31:0] ah;
            logic [31:0] ch;
            if (p < 2) signature |= lane(b, p, 0);
            else if (p >= 10 && p < 14) data_start |= lane(b, p, 10);
            else if (p >= 14 && p < 18) info_len |= lane(b, p, 14);
            else if (p >= 18 && p < 22) width |= lane(b, p, 18);
            else if (p >= 22 && p < 26) height |= lane(b, p, 22);
            else if (p >= 26 && p < 28) planes |= lane(b, p, 26);
            else if (p >= 28 && p < 30) bpp |= lane(b, p, 28);
            else if (p >= 30 && p < 34) compression |= lane(b, p, 30);

            if (p == 32'(POS_SIG_DONE) && signature != 32'(BMP_SIGNATURE)) begin
                push_error(ERR_SIGNATURE, 1'b1);
                return;
            end
            if (p == 32'(POS_DIB_DONE) && info_len < DIB_MIN_SIZE) begin
                push_error(ERR_DIB_SMALL, 1'b1);
                return;
            end
            if (p == 32'(POS_PLANES_DONE) && planes != 32'd1) begin
                push_error(ERR_PLANES, 1'b1);
                return;
            end
            if (p != 32'(POS_HDR_LAST)) return;

            ah = height_mag();
            if (width[31] || width == 0 || height == 0) push_error(ERR_DIMS, 1'b1);
            else if (compression != 0) push_error(ERR_COMPRESS, 1'b1);
            else if (bpp != 32'(BPP_24) && bpp != 32'(BPP_8)) push_error(ERR_DEPTH, 1'b1);
            else if (width > FRAME_MAX_W || ah > FRAME_MAX_H) push_error(ERR_TOO_BIG, 1'b1);
            else if (data_start < HDR_SIZE) push_error(ERR_OFFSET, 1'b1);
            else begin
                row_count     = '0;
                stride_column = '0;
                // bottom-up files start at the last frame row
                row_base      = height[31] ? 32'd0 : (ah - 1) * row_len();
                phase         = PARSE_SKIP;
                ch            = channels();
                r = '0;
                r.result_kind   = KIND_INFO;
                r.frame_width   = width[DIM_W-1:0];
                r.frame_height  = ah[DIM_W-1:0];
                r.channel_count = ch[1:0];
                expected_results.push_back(r);
            end
        endfunction

        function void note_byte(t_in_item it);
            logic [31:0] p;
            logic [31:0] rb;
            logic [31:0] stride;
            logic [31:0] ah;
            logic [31:0] addr;
            bit          finished;
            t_out_item   r;
            p = position;
            if (it.end_of_stream) begin
                finished = (phase == PARSE_DONE || phase == PARSE_ERROR);
                rearm();
                if (!finished) push_error(ERR_TRUNCATED, 1'b0);
                return;
            end
            if (position != '1) position++;
            if (phase == PARSE_HEADER) begin
                header_byte(p, it.stream_byte);
                return;
            end
            if (phase == PARSE_SKIP && p >= data_start) phase = PARSE_PIXELS;
            if (phase == PARSE_PIXELS) begin
                rb     = row_len();
                stride = (rb + 3) & ~32'd3;
                ah     = height_mag();
                if (stride_column < rb) begin
                    addr = row_base + stride_column;
                    r = '0;
                    r.result_kind  = KIND_PIXEL;
                    r.pixel_byte   = it.stream_byte;
                    r.dest_address = addr[ADDR_W-1:0];
                    r.last         = (row_count + 1 == ah) && (stride_column + 1 == rb);
                    expected_results.push_back(r);
                end
                stride_column++;
                // drop padding, then step to the next frame row
                if (stride_column >= stride) begin
                    stride_column = '0;
                    row_count++;
                    if (height[31]) row_base += rb;
                    else row_base -= rb;
                    if (row_count >= ah) phase = PARSE_DONE;
                end
            end
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", msg);
        endfunction

        function void compare_result(t_out_item got);
            t_out_item want;
            bit        bad;
            if (expected_results.size() == 0) begin
                flag($sformatf("result with nothing expected: %p", got));
                return;
            end
            want = expected_results.pop_front();
            bad = (got.result_kind   !== want.result_kind)
               || (got.pixel_byte    !== want.pixel_byte)
               || (got.dest_address  !== want.dest_address)
               || (got.frame_width   !== want.frame_width)
               || (got.frame_height  !== want.frame_height)
               || (got.channel_count !== want.channel_count)
               || (got.error_code    !== want.error_code)
               || (got.last          !== want.last);
            if (bad) begin
                flag($sformatf({"exp/got kind %0d/%0d byte %02h/%02h addr %0d/%0d ",
                                "w %0d/%0d h %0d/%0d ch %0d/%0d err %0d/%0d last %0d/%0d"},
                               want.result_kind, got.result_kind,
                               want.pixel_byte, got.pixel_byte,
                               want.dest_address, got.dest_address,
                               want.frame_width, got.frame_width,
                               want.frame_height, got.frame_height,
                               want.channel_count, got.channel_count,
                               want.error_code, got.error_code,
                               want.last, got.last));
            end
            case (want.result_kind)
                KIND_INFO:  frame_infos++;
                KIND_PIXEL: begin
                    pixel_items++;
                    if (want.last) frame_ends++;
                end
                default: begin
                    error_items++;
                    codes_seen[want.error_code] = 1'b1;
                end
            endcase
        endfunction
    endclass

endpackage

[dv/tb_bmp_stream_decoder.sv]
`timescale 1ns / 1ps

module tb_bmp_stream_decoder;
    import bsd_pkg::*;
    import bmp_result_tracker_pkg::*;

    localparam int RANDOM_ITEMS = 100;
    localparam int BODY_CAP     = 17000;

    typedef struct {
        logic [15:0] sig;
        logic [31:0] offset;
        logic [31:0] dib;
        logic [31:0] width;
        logic [31:0] height;
        logic [15:0] planes;
        logic [15:0] bpp;
        logic [31:0] compr;
    } bmp_header_t;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    bmp_result_tracker tracker;
    logic [7:0]        file_bytes[$];
    bit                tx_idle = 1'b0;
    bit                rx_idle = 1'b0;
    int                items_sent = 0;
    int                files_sent = 0;
    int                random_start = 0;
    int                stall_left = 0;

    bmp_stream_decoder #(
        .MAX_WIDTH  (FRAME_MAX_W),
        .MAX_HEIGHT (FRAME_MAX_H)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("timeout: decoder stopped making progress");
        $display("status: fail");
        $finish;
    end

    // receiver: while rx_idle is set, ready drops at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (rx_idle && stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (rx_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) tracker.compare_result(o_out_data);
    end

    task automatic send_item(input logic [7:0] b, input logic eos);
        t_in_item it;
        it.stream_byte   = b;
        it.end_of_stream = eos;
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        tracker.note_byte(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    function automatic bmp_header_t good_header(int w, int h, logic [15:0] depth, int gap);
        bmp_header_t hd;
        hd.sig    = BMP_SIGNATURE;
        hd.offset = HDR_SIZE + 32'(gap);
        hd.dib    = DIB_MIN_SIZE + 32'($urandom_range(0, 84));
        hd.width  = 32'(w);
        hd.height = 32'(h);
        hd.planes = 16'd1;
        hd.bpp    = depth;
        hd.compr  = '0;
        return hd;
    endfunction

    // gap plus padded rows for a header that decodes; capped for huge frames
    function automatic int frame_body_len(bmp_header_t hd);
        logic [31:0] ah;
        int          rb;
        int          stride;
        ah = hd.height[31] ? (32'd0 - hd.height) : hd.height;
        if (hd.width == 0 || hd.width > FRAME_MAX_W || ah == 0 || ah > FRAME_MAX_H
            || hd.offset < HDR_SIZE || hd.offset > 1000) return 0;
        rb     = int'(hd.width) * ((hd.bpp == BPP_24) ? 3 : 1);
        stride = (rb + 3) & ~3;
        if (stride * int'(ah) > BODY_CAP) return int'(hd.offset - HDR_SIZE) + BODY_CAP;
        return int'(hd.offset - HDR_SIZE) + stride * int'(ah);
    endfunction

    task automatic build_file(input bmp_header_t hd, input int trailing);
        logic [7:0] hdr[54];
        int         body;
        foreach (hdr[k]) hdr[k] = 8'($urandom);
        hdr[0] = hd.sig[7:0];
        hdr[1] = hd.sig[15:8];
        for (int k = 0; k < 4; k++) begin
            hdr[10 + k] = hd.offset[8*k +: 8];
            hdr[14 + k] = hd.dib[8*k +: 8];
            hdr[18 + k] = hd.width[8*k +: 8];
            hdr[22 + k] = hd.height[8*k +: 8];
            hdr[30 + k] = hd.compr[8*k +: 8];
        end
        for (int k = 0; k < 2; k++) begin
            hdr[26 + k] = hd.planes[8*k +: 8];
            hdr[28 + k] = hd.bpp[8*k +: 8];
        end
        file_bytes.delete();
        foreach (hdr[k]) file_bytes.push_back(hdr[k]);
        body = frame_body_len(hd) + trailing;
        repeat (body) file_bytes.push_back(8'($urandom));
    endtask

    // keep < 0 sends the whole file; pause_at holds the sender until drained
    task automatic send_file(input int keep, input int pause_at);
        int n;
        n = (keep < 0 || keep > file_bytes.size()) ? file_bytes.size() : keep;
        for (int k = 0; k < n; k++) begin
            if (k == pause_at) wait_drained();
            send_item(file_bytes[k], 1'b0);
        end
        send_item(8'($urandom), 1'b1);
        files_sent++;
    endtask

    task automatic run_file(input bmp_header_t hd, input int keep, input int trailing,
                            input int pause_at);
        build_file(hd, trailing);
        send_file(keep, pause_at);
    endtask

    task automatic directed_files();
        bmp_header_t hd;
        // empty stream
        run_file(good_header(1, 1, BPP_8, 0), 0, 0, -1);
        // bad signature, then bytes that must be dropped
        hd = good_header(2, 2, BPP_8, 0);
        hd.sig = 16'h4e42;
        run_file(hd, 6, 0, -1);
        hd = good_header(2, 2, BPP_8, 0);
        hd.dib = 32'd39;
        run_file(hd, 24, 0, -1);
        // bottom-up frame with trailing bytes after it is finished
        hd = good_header(3, 2, BPP_24, 0);
        hd.dib = '1;
        run_file(hd, -1, 3, -1);
        // top-down frame past a gap; hold the sender mid-frame until drained
        run_file(good_header(5, -3, BPP_8, 6), -1, 0, 62);
        // end inside the last row's padding
        run_file(good_header(1, 1, BPP_8, 0), 56, 0, -1);
        // largest sizes, cut after the first pixel bytes
        run_file(good_header(FRAME_MAX_W, FRAME_MAX_H, BPP_24, 0), 56, 0, -1);
        run_file(good_header(FRAME_MAX_W, -FRAME_MAX_H, BPP_24, 0), 56, 0, -1);
    endtask

    task automatic break_header(inout bmp_header_t hd);
        int h;
        case ($urandom_range(0, 8))
            0: hd.sig = 16'($urandom);
            1: hd.dib = 32'($urandom_range(0, 39));
            2: hd.planes = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(2, 65535));
            3: hd.width = $urandom_range(0, 1) ? 32'd0 : (32'($urandom) | 32'h8000_0000);
            4: hd.height = '0;
            5: hd.compr = $urandom_range(0, 1) ? 32'($urandom_range(1, 3)) : 32'($urandom);
            6: hd.bpp = $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom);
            7: begin
                h = $urandom_range(FRAME_MAX_H + 1, 70000);
                if ($urandom_range(0, 1)) hd.width = 32'(h);
                else hd.height = $urandom_range(0, 1) ? 32'(h) : 32'(-h);
            end
            default: hd.offset = 32'($urandom_range(0, 53));
        endcase
    endtask

    task automatic random_file();
        bmp_header_t hd;
        int          pick;
        int          h;
        int          keep;
        int          trailing;
        h = $urandom_range(1, 4);
        if ($urandom_range(0, 1)) h = -h;
        hd = good_header($urandom_range(1, 6), h, $urandom_range(0, 1) ? BPP_24 : BPP_8,
                         $urandom_range(0, 1) ? 0 : $urandom_range(1, 6));
        trailing = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        keep = -1;
        pick = $urandom_range(0, 99);
        if (pick >= 72) begin
            break_header(hd);
            if (pick >= 92) break_header(hd);
        end
        build_file(hd, trailing);
        // cut some streams short anywhere, header included
        if (pick >= 60 && pick < 72) keep = $urandom_range(0, file_bytes.size() - 1);
        send_file(keep, -1);
    endtask

    initial begin
        tracker = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        directed_files();
        wait_drained();

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            // no idling in the closing stretch
            if (items_sent - random_start > RANDOM_ITEMS * 4 / 5) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end else begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            random_file();
            if ($urandom_range(0, 7) == 0) wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("covered %0d files in %0d input items (%0d random), up to 4096 wide and high",
                 files_sent, items_sent, items_sent - random_start);
        $display("checked %0d frame infos, %0d pixel bytes, %0d frame ends, %0d errors (codes %b)",
                 tracker.frame_infos, tracker.pixel_items, tracker.frame_ends,
                 tracker.error_items, tracker.codes_seen[8:0]);
        if (tracker.pending() != 0)
            $display("%0d expected results never arrived", tracker.pending());
        if (tracker.mismatches > 10)
            $display("%0d mismatches in total", tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[bmp_stream_decoder.f]
+incdir+rtl
rtl/bsd_pkg.sv
rtl/bsd_hdr_chk.sv
rtl/bmp_stream_decoder.sv
dv/bmp_result_tracker_pkg.sv
dv/tb_bmp_stream_decoder.sv
